/* sv/mtf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front rank encoder package
// Shared widths, the list-update control bundle and the rank codeword encoder.
// ----------------------------------------------------------------------------
package mtf_pkg;

   localparam int SYM_W    = 8;
   localparam int RANK_W   = 8;
   localparam int CODE_W   = 15;
   localparam int LEN_W    = 4;
   localparam int LIST_CAP = 256;

   // Prefix classes of the codeword.
   localparam logic [RANK_W-1:0] CLASS1_LAST = 8'd3;
   localparam logic [RANK_W-1:0] CLASS2_BASE = 8'd4;
   localparam logic [RANK_W-1:0] CLASS2_LAST = 8'd18;
   localparam logic [RANK_W-1:0] CLASS3_BASE = 8'd19;
   localparam logic [LEN_W-1:0]  LEN_MAX     = 4'd15;

   typedef struct packed {
      logic              move;
      logic [RANK_W-1:0] rank;
   } mtf_shift_type;

   typedef struct packed {
      logic [CODE_W-1:0] bits;
      logic [LEN_W-1:0]  len;
   } mtf_code_type;

   // Unary-style prefix of ones, then the remainder LSB first with each bit
   // inverted, stopping once the remainder has been shifted down to zero.
   function automatic mtf_code_type mtf_encode(input logic [RANK_W-1:0] rank);
      logic [RANK_W-1:0] r;
      logic [LEN_W-1:0]  n;
      logic [CODE_W-1:0] b;
      mtf_code_type      c;
      if (rank == '0) begin
         b = '0;
         n = 4'd1;
         r = '0;
      end else if (rank <= CLASS1_LAST) begin
         b = 15'h0001;
         n = 4'd1;
         r = rank - 8'd1;
      end else if (rank <= CLASS2_LAST) begin
         b = 15'h0007;
         n = 4'd3;
         r = rank - CLASS2_BASE;
      end else begin
         b = 15'h007f;
         n = 4'd7;
         r = rank - CLASS3_BASE;
      end
      for (int k = 0; k < RANK_W; k++) begin
         if (r != '0 && n < LEN_MAX) begin
            b[n] = ~r[0];
            n = n + 4'd1;
            r = r >> 1;
         end
      end
      c.bits = b;
      c.len  = n;
      return c;
   endfunction

endpackage

/* sv/mtf_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front request channel
// Valid/ready channel carrying one input symbol per transaction.
// ----------------------------------------------------------------------------
interface mtf_req_if;
   logic                      valid;
   logic                      ready;
   logic [mtf_pkg::SYM_W-1:0] symbol;

   modport source (output valid, output symbol, input ready);
   modport sink   (input valid, input symbol, output ready);
endinterface

/* sv/mtf_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front response channel
// Valid/ready channel carrying the rank and its codeword per transaction.
// ----------------------------------------------------------------------------
interface mtf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mtf_pkg::RANK_W-1:0] rank;
   logic [mtf_pkg::CODE_W-1:0] code_bits;
   logic [mtf_pkg::LEN_W-1:0]  code_length;

   modport source (output valid, output rank, output code_bits, output code_length,
                   input ready);
   modport sink   (input valid, input rank, input code_bits, input code_length,
                   output ready);
endinterface

/* sv/mtf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front list cell
// Holds one list entry, flags a match against the current symbol and takes
// its neighbor's entry when the list shifts over it.
// ----------------------------------------------------------------------------
module mtf_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [mtf_pkg::SYM_W-1:0]  init_value,
   input  logic [mtf_pkg::RANK_W-1:0] cell_index,
   input  logic [mtf_pkg::SYM_W-1:0]  symbol,
   input  logic [mtf_pkg::SYM_W-1:0]  prev_entry,
   input  mtf_pkg::mtf_shift_type     shift,
   output logic [mtf_pkg::SYM_W-1:0]  entry,
   output logic                       match
);
   import mtf_pkg::*;

   logic [SYM_W-1:0] entry_ff;
   logic [SYM_W-1:0] entry_in;

   // Every cell at or ahead of the matched slot moves back by one.
   always_comb begin
      entry_in = entry_ff;
      if (shift.move && cell_index <= shift.rank) begin
         entry_in = prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= init_value;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;
   assign match = (entry_ff == symbol);

endmodule

/* sv/mtf_rank_tree.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front rank tree
// Four-level registered priority tree that finds the lowest matching slot
// among the list cells, four leaves per node at each level.
// ----------------------------------------------------------------------------
module mtf_rank_tree (
   input  logic                         clock,
   input  logic [mtf_pkg::LIST_CAP-1:0] match_vec,
   output logic                         root_hit,
   output logic [mtf_pkg::RANK_W-1:0]   root_index
);
   import mtf_pkg::*;

   function automatic logic [1:0] first4(input logic [3:0] v);
      logic [1:0] s;
      if (v[0]) begin
         s = 2'd0;
      end else if (v[1]) begin
         s = 2'd1;
      end else if (v[2]) begin
         s = 2'd2;
      end else begin
         s = 2'd3;
      end
      return s;
   endfunction

   logic [63:0] hit1_ff;
   logic [63:0] hit1_in;
   logic [1:0]  idx1_ff [64];
   logic [1:0]  idx1_in [64];
   logic [15:0] hit2_ff;
   logic [15:0] hit2_in;
   logic [3:0]  idx2_ff [16];
   logic [3:0]  idx2_in [16];
   logic [3:0]  hit3_ff;
   logic [3:0]  hit3_in;
   logic [5:0]  idx3_ff [4];
   logic [5:0]  idx3_in [4];
   logic        root_hit_ff;
   logic        root_hit_in;
   logic [7:0]  root_idx_ff;
   logic [7:0]  root_idx_in;
   logic [1:0]  root_sel;

   always_comb begin
      for (int j = 0; j < 64; j++) begin
         hit1_in[j] = |match_vec[4*j +: 4];
         idx1_in[j] = first4(match_vec[4*j +: 4]);
      end
   end

   always_comb begin
      logic [1:0] sel;
      for (int j = 0; j < 16; j++) begin
         sel        = first4(hit1_ff[4*j +: 4]);
         hit2_in[j] = |hit1_ff[4*j +: 4];
         idx2_in[j] = {sel, idx1_ff[{4'(j), sel}]};
      end
   end

   always_comb begin
      logic [1:0] sel;
      for (int j = 0; j < 4; j++) begin
         sel        = first4(hit2_ff[4*j +: 4]);
         hit3_in[j] = |hit2_ff[4*j +: 4];
         idx3_in[j] = {sel, idx2_ff[{2'(j), sel}]};
      end
   end

   assign root_sel    = first4(hit3_ff);
   assign root_hit_in = |hit3_ff;
   assign root_idx_in = {root_sel, idx3_ff[root_sel]};

   always_ff @(posedge clock) begin
      hit1_ff     <= hit1_in;
      idx1_ff     <= idx1_in;
      hit2_ff     <= hit2_in;
      idx2_ff     <= idx2_in;
      hit3_ff     <= hit3_in;
      idx3_ff     <= idx3_in;
      root_hit_ff <= root_hit_in;
      root_idx_ff <= root_idx_in;
   end

   assign root_hit   = root_hit_ff;
   assign root_index = root_idx_ff;

endmodule

/* sv/move_to_front_rank_encoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front rank encoder
// Ranks each input byte in a recency list, moves it to the front and emits
// the rank with its variable-length codeword.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time and steps through the acceptance
// state, four states through the registered rank tree (the first of which also
// compares the symbol against every list cell), and a move state that shifts
// the cell chain and loads the result register once that register is free. A
// new request is accepted in the cycle after the move, even while the previous
// result is still waiting to be taken. The list holds ALPHABET_SIZE cells and
// comes out of reset as ALPHABET_SIZE-1 down to 0; a symbol not in the list
// takes the last slot's rank.
module move_to_front_rank_encoder_top #(
   parameter int ALPHABET_SIZE = 256
) (
   input logic       clock,
   input logic       reset,
   mtf_req_if.sink   req_ch,
   mtf_rsp_if.source rsp_ch
);
   import mtf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_L1   = 6'b000010,
      ST_L2   = 6'b000100,
      ST_L3   = 6'b001000,
      ST_L4   = 6'b010000,
      ST_MOVE = 6'b100000
   } state_type;

   localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(ALPHABET_SIZE - 1);

   state_type         state_ff;
   state_type         state_in;
   logic [SYM_W-1:0]  sym_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [RANK_W-1:0] rsp_rank_ff;
   logic [CODE_W-1:0] rsp_bits_ff;
   logic [LEN_W-1:0]  rsp_len_ff;

   logic              req_fire;
   logic              move_fire;
   logic [LIST_CAP-1:0] match_vec;
   logic [SYM_W-1:0]  entry_w [ALPHABET_SIZE];
   logic              root_hit;
   logic [RANK_W-1:0] root_index;
   logic [RANK_W-1:0] rank_w;
   mtf_shift_type     shift;
   mtf_code_type      code_w;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign move_fire    = (state_ff == ST_MOVE) && (!rsp_valid_ff || rsp_ch.ready);

   assign rank_w      = root_hit ? root_index : LAST_RANK;
   assign shift.move  = move_fire;
   assign shift.rank  = rank_w;
   assign code_w      = mtf_encode(rank_w);

   genvar gi;
   generate
      for (gi = 0; gi < ALPHABET_SIZE; gi++) begin : g_cell
         logic [SYM_W-1:0] prev_w;
         if (gi == 0) begin : g_head
            assign prev_w = sym_ff;
         end else begin : g_body
            assign prev_w = entry_w[gi-1];
         end
         mtf_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .init_value (SYM_W'(ALPHABET_SIZE - 1 - gi)),
            .cell_index (RANK_W'(gi)),
            .symbol     (sym_ff),
            .prev_entry (prev_w),
            .shift      (shift),
            .entry      (entry_w[gi]),
            .match      (match_vec[gi])
         );
      end
      if (ALPHABET_SIZE < LIST_CAP) begin : g_pad
         assign match_vec[LIST_CAP-1:ALPHABET_SIZE] = '0;
      end
   endgenerate

   mtf_rank_tree u_rank_tree (
      .clock      (clock),
      .match_vec  (match_vec),
      .root_hit   (root_hit),
      .root_index (root_index)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_L1;
            end
         end
         ST_L1:   state_in = ST_L2;
         ST_L2:   state_in = ST_L3;
         ST_L3:   state_in = ST_L4;
         ST_L4:   state_in = ST_MOVE;
         ST_MOVE: begin
            if (move_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (move_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sym_ff <= req_ch.symbol;
      end
      if (move_fire) begin
         rsp_rank_ff <= rank_w;
         rsp_bits_ff <= code_w.bits;
         rsp_len_ff  <= code_w.len;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.rank        = rsp_rank_ff;
   assign rsp_ch.code_bits   = rsp_bits_ff;
   assign rsp_ch.code_length = rsp_len_ff;

`ifndef SYNTHESIS
   a_accept_starts_search: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_L1)
      else $error("accepted transaction did not start the rank search");

   a_front_holds_symbol: assert property (@(posedge clock) disable iff (reset)
      ($past(move_fire) && !$past(reset)) |-> entry_w[0] == $past(sym_ff))
      else $error("list head does not hold the last symbol after the move");

   a_result_from_move: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MOVE))
      else $error("result appeared without a list update");

   a_hit_matches_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE && root_hit) |-> entry_w[root_index] == sym_ff)
      else $error("rank tree points at a slot that does not hold the symbol");

   a_rank_in_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_rank_ff <= LAST_RANK)
      else $error("reported rank lies beyond the list");
`endif

endmodule
